// File: hdl/fixed_height_radix_map_defines.svh
// shared assertion macros
`ifndef FIXED_HEIGHT_RADIX_MAP_DEFINES_SVH
`define FIXED_HEIGHT_RADIX_MAP_DEFINES_SVH

// condition that must hold at every edge out of reset
`define FRHM_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define FRHM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/frhm_pkg.sv
`timescale 1ns / 1ps
package frhm_pkg;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_EXISTS    = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_NO_MEMORY = 3'd4;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic CFG_CHUNK_WIDTH = 1'b0;
    localparam logic CFG_LEVEL_COUNT = 1'b1;

    // clearing sweep status
    typedef struct packed {
        logic busy;
        logic pool_row;
    } clr_t;

endpackage

// File: hdl/frhm_cfg.sv
`timescale 1ns / 1ps
module frhm_cfg #(
    parameter int MAX_CHUNK_BITS = 4,
    parameter int MAX_LEVELS     = 8,
    parameter int POOL_NODES     = 256,
    parameter int AW             = 12,
    parameter int SLOTS          = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [3:0]        cfg_wdata,
    output logic [2:0]        eff_chunk,
    output logic [3:0]        eff_levels,
    output logic [AW-1:0]     sweep_addr,
    output frhm_pkg::clr_t    clr
);

    logic [2:0]    chunk_reg;
    logic [3:0]    levels_reg;
    logic [AW-1:0] sweep_reg;
    logic          busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_reg  <= 3'd4;
            levels_reg <= 4'd8;
            sweep_reg  <= '0;
            busy_reg   <= 1'b1;
        end else if (cfg_wr_en) begin
            // any write reshapes the tree, so the map is emptied again
            if (cfg_index == frhm_pkg::CFG_CHUNK_WIDTH) begin
                chunk_reg <= cfg_wdata[2:0];
            end else begin
                levels_reg <= cfg_wdata;
            end
            sweep_reg <= '0;
            busy_reg  <= 1'b1;
        end else if (busy_reg) begin
            if (sweep_reg == AW'(SLOTS - 1)) begin
                busy_reg <= 1'b0;
            end else begin
                sweep_reg <= sweep_reg + 1'b1;
            end
        end
    end

    always_comb begin
        if (chunk_reg == 3'd0) begin
            eff_chunk = 3'd1;
        end else if ({1'b0, chunk_reg} > 4'(MAX_CHUNK_BITS)) begin
            eff_chunk = 3'(MAX_CHUNK_BITS);
        end else begin
            eff_chunk = chunk_reg;
        end
        if (levels_reg == 4'd0) begin
            eff_levels = 4'd1;
        end else if ({1'b0, levels_reg} > 5'(MAX_LEVELS)) begin
            eff_levels = 4'(MAX_LEVELS);
        end else begin
            eff_levels = levels_reg;
        end
    end

    assign sweep_addr   = sweep_reg;
    assign clr.busy     = busy_reg;
    assign clr.pool_row = sweep_reg < AW'(POOL_NODES);

endmodule

// File: hdl/fixed_height_radix_map.sv
`timescale 1ns / 1ps
// fixed_height_radix_map: key to value map kept as a fixed-height radix tree.
// input words on s_ (mode, key, item_value), one result word per input on m_
// (status, found_value). configuration: cfg_wr_en with cfg_index 0 sets the
// chunk width, 1 sets the level count; every write empties the map.
// the tree lives in a slot memory (one row of 2^MAX_CHUNK_BITS slots per
// node) and a child count memory, both single port, and a free node list with its
// own write address, all with registered reads, read-modify-written in turn.
// per item, for each level a walk read then an evaluate step; insert adds
// a child count read and write for each slot it fills and an allocation
// step for each node it builds, remove a child count read and write for
// the leaf node and for each parent of a node it prunes on the way up.
// the slot memory port sets the pace: one slot access per walk step.
// after reset or any configuration write a clearing pass over all
// POOL_NODES * 2^MAX_CHUNK_BITS slots (4096 by default) runs and s_tready
// stays low meanwhile. a new word is taken while a result still waits on m_;
// while m_tready is low the finished result is held and no further word is
// taken once the next one has finished.
`include "fixed_height_radix_map_defines.svh"
module fixed_height_radix_map #(
    parameter int KEY_BITS       = 32,
    parameter int MAX_CHUNK_BITS = 4,
    parameter int MAX_LEVELS     = 8,
    parameter int POOL_NODES     = 256,
    parameter int VALUE_BITS     = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // mode[1:0], key[33:2], item_value[65:34]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[2:0], found_value[34:3]
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_wdata
);

    localparam int FANOUT = 1 << MAX_CHUNK_BITS;
    localparam int SLOTS  = POOL_NODES * FANOUT;
    localparam int NB     = $clog2(POOL_NODES);
    localparam int AW     = NB + MAX_CHUNK_BITS;
    localparam int HB     = $clog2(POOL_NODES + 1);
    localparam int CB     = MAX_CHUNK_BITS + 1;
    localparam int VW     = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int KW     = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int SW     = (VW > NB + 1) ? VW : NB + 1;
    localparam int LB     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_ALLOC, S_WALK_RD, S_WALK_EV, S_CNT_RD, S_CNT_WR,
        S_DEC_RD, S_DEC_WR, S_FIN
    } state_t;

    logic [2:0]     eff_chunk;
    logic [3:0]     eff_levels;
    logic [AW-1:0]  sweep_addr;
    frhm_pkg::clr_t clr;

    frhm_cfg #(
        .MAX_CHUNK_BITS(MAX_CHUNK_BITS),
        .MAX_LEVELS    (MAX_LEVELS),
        .POOL_NODES    (POOL_NODES),
        .AW            (AW),
        .SLOTS         (SLOTS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .eff_chunk (eff_chunk),
        .eff_levels(eff_levels),
        .sweep_addr(sweep_addr),
        .clr       (clr)
    );

    // memories
    logic [SW-1:0] slot_mem [SLOTS];
    logic [CB-1:0] cnt_mem  [POOL_NODES];
    logic [NB-1:0] free_mem [POOL_NODES];

    logic          slot_we;
    logic [AW-1:0] slot_addr;
    logic [SW-1:0] slot_wd;
    logic [SW-1:0] slot_rd;
    logic          cnt_we;
    logic [NB-1:0] cnt_addr;
    logic [CB-1:0] cnt_wd;
    logic [CB-1:0] cnt_rd;
    logic          free_we;
    logic [NB-1:0] free_waddr;
    logic [NB-1:0] free_wd;
    logic [NB-1:0] free_rd;
    logic [HB-1:0] head_reg;

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_addr] <= slot_wd;
        end
        slot_rd <= slot_mem[slot_addr];
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_addr] <= cnt_wd;
        end
        cnt_rd <= cnt_mem[cnt_addr];
    end

    // free list: pops read head-1, pushes write head
    always_ff @(posedge aclk) begin
        if (free_we) begin
            free_mem[free_waddr] <= free_wd;
        end
        free_rd <= free_mem[NB'(head_reg - 1'b1)];
    end

    // control registers
    state_t        state_reg;
    logic [1:0]    mode_reg;
    logic [KW-1:0] key_reg;
    logic [VW-1:0] val_reg;
    logic [3:0]    lv_reg;
    logic [NB-1:0] node_reg;
    logic [NB-1:0] child_reg;
    logic [AW-1:0] saddr_reg;
    logic [2:0]    status_reg;
    logic [VW-1:0] found_reg;
    logic          root_pres_reg;
    logic [NB-1:0] root_reg;
    logic          alloc_root_reg;
    logic [NB-1:0]             path_node_reg [MAX_LEVELS];
    logic [MAX_CHUNK_BITS-1:0] path_idx_reg  [MAX_LEVELS];
    logic          m_valid_reg;
    logic [2:0]    m_status_reg;
    logic [VW-1:0] m_found_reg;

    logic [MAX_CHUNK_BITS-1:0] idx;
    logic [AW-1:0]             walk_addr;
    logic                      last_lv;
    logic                      child_ok;
    logic [CB-1:0]             dec_cnt;
    logic [LB-1:0]             up_lv;
    logic [1:0]                in_mode;
    logic [VW-1:0]             in_val;
    logic                      accept;

    assign in_mode   = s_tdata[1:0];
    assign in_val    = s_tdata[34 +: VW];
    assign s_tready  = (state_reg == S_IDLE) && !clr.busy;
    assign accept    = s_tvalid && s_tready;
    assign idx       = MAX_CHUNK_BITS'(key_reg)
                       & ~({MAX_CHUNK_BITS{1'b1}} << eff_chunk);
    assign walk_addr = {node_reg, idx};
    assign last_lv   = lv_reg == (eff_levels - 4'd1);
    // links outside the pool count as empty
    assign child_ok  = (slot_rd != '0) && (slot_rd <= SW'(POOL_NODES));
    assign dec_cnt   = (cnt_rd != '0) ? cnt_rd - 1'b1 : cnt_rd;
    assign up_lv     = LB'(lv_reg - 4'd1);

    always_comb begin
        slot_we    = 1'b0;
        slot_addr  = walk_addr;
        slot_wd    = '0;
        cnt_we     = 1'b0;
        cnt_addr   = node_reg;
        cnt_wd     = '0;
        free_we    = 1'b0;
        free_waddr = NB'(head_reg);
        free_wd    = node_reg;
        if (clr.busy) begin
            slot_we    = 1'b1;
            slot_addr  = sweep_addr;
            cnt_we     = clr.pool_row;
            cnt_addr   = sweep_addr[NB-1:0];
            free_we    = clr.pool_row;
            free_waddr = sweep_addr[NB-1:0];
            free_wd    = sweep_addr[NB-1:0];
        end else begin
            case (state_reg)
                S_ALLOC: begin
                    if (!alloc_root_reg) begin
                        slot_we   = 1'b1;
                        slot_addr = saddr_reg;
                        slot_wd   = SW'(free_rd) + 1'b1;
                    end
                end
                S_WALK_EV: begin
                    slot_addr = saddr_reg;
                    if (last_lv && mode_reg == frhm_pkg::MODE_INSERT && slot_rd == '0) begin
                        slot_we = 1'b1;
                        slot_wd = SW'(val_reg);
                    end else if (last_lv && mode_reg == frhm_pkg::MODE_REMOVE
                                 && slot_rd != '0) begin
                        slot_we = 1'b1;
                    end
                end
                S_CNT_WR: begin
                    cnt_we = 1'b1;
                    cnt_wd = cnt_rd + 1'b1;
                end
                S_DEC_WR: begin
                    cnt_we = 1'b1;
                    cnt_wd = dec_cnt;
                    if (dec_cnt == '0) begin
                        free_we = head_reg < HB'(POOL_NODES);
                        if (lv_reg != 4'd0) begin
                            // unlink the empty node from its parent
                            slot_we   = 1'b1;
                            slot_addr = {path_node_reg[up_lv], path_idx_reg[up_lv]};
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= HB'(POOL_NODES);
            root_pres_reg <= 1'b0;
            root_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && state_reg != S_FIN) begin
                m_valid_reg <= 1'b0;
            end
            if (clr.busy) begin
                head_reg      <= HB'(POOL_NODES);
                root_pres_reg <= 1'b0;
                root_reg      <= '0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        mode_reg  <= in_mode;
                        key_reg   <= s_tdata[2 +: KW];
                        val_reg   <= in_val;
                        found_reg <= '0;
                        lv_reg    <= 4'd0;
                        node_reg  <= root_reg;
                        state_reg <= S_FIN;
                        case (in_mode)
                            frhm_pkg::MODE_INSERT: begin
                                if (in_val == '0) begin
                                    status_reg <= frhm_pkg::ST_INVALID;
                                end else if (root_pres_reg) begin
                                    state_reg <= S_WALK_RD;
                                end else if (head_reg == '0) begin
                                    status_reg <= frhm_pkg::ST_NO_MEMORY;
                                end else begin
                                    alloc_root_reg <= 1'b1;
                                    state_reg      <= S_ALLOC;
                                end
                            end
                            frhm_pkg::MODE_LOOKUP, frhm_pkg::MODE_REMOVE: begin
                                if (root_pres_reg) begin
                                    state_reg <= S_WALK_RD;
                                end else begin
                                    status_reg <= frhm_pkg::ST_NOT_FOUND;
                                end
                            end
                            default: begin
                                status_reg <= frhm_pkg::ST_NOT_FOUND;
                            end
                        endcase
                    end
                end
                S_ALLOC: begin
                    head_reg <= head_reg - 1'b1;
                    if (alloc_root_reg) begin
                        root_reg      <= free_rd;
                        root_pres_reg <= 1'b1;
                        node_reg      <= free_rd;
                        state_reg     <= S_WALK_RD;
                    end else begin
                        child_reg <= free_rd;
                        state_reg <= S_CNT_RD;
                    end
                end
                S_WALK_RD: begin
                    saddr_reg                  <= walk_addr;
                    path_node_reg[lv_reg[LB-1:0]] <= node_reg;
                    path_idx_reg[lv_reg[LB-1:0]]  <= idx;
                    state_reg                  <= S_WALK_EV;
                end
                S_WALK_EV: begin
                    if (last_lv) begin
                        state_reg <= S_FIN;
                        if (slot_rd == '0) begin
                            if (mode_reg == frhm_pkg::MODE_INSERT) begin
                                state_reg <= S_CNT_RD;
                            end else begin
                                status_reg <= frhm_pkg::ST_NOT_FOUND;
                            end
                        end else if (mode_reg == frhm_pkg::MODE_INSERT) begin
                            status_reg <= frhm_pkg::ST_EXISTS;
                        end else begin
                            found_reg  <= VW'(slot_rd);
                            status_reg <= frhm_pkg::ST_OK;
                            if (mode_reg == frhm_pkg::MODE_REMOVE) begin
                                state_reg <= S_DEC_RD;
                            end
                        end
                    end else if (child_ok) begin
                        node_reg  <= NB'(slot_rd - 1'b1);
                        lv_reg    <= lv_reg + 4'd1;
                        key_reg   <= key_reg >> eff_chunk;
                        state_reg <= S_WALK_RD;
                    end else if (mode_reg == frhm_pkg::MODE_INSERT) begin
                        if (head_reg == '0) begin
                            status_reg <= frhm_pkg::ST_NO_MEMORY;
                            state_reg  <= S_FIN;
                        end else begin
                            alloc_root_reg <= 1'b0;
                            state_reg      <= S_ALLOC;
                        end
                    end else begin
                        status_reg <= frhm_pkg::ST_NOT_FOUND;
                        state_reg  <= S_FIN;
                    end
                end
                S_CNT_RD: begin
                    state_reg <= S_CNT_WR;
                end
                S_CNT_WR: begin
                    if (last_lv) begin
                        status_reg <= frhm_pkg::ST_OK;
                        state_reg  <= S_FIN;
                    end else begin
                        node_reg  <= child_reg;
                        lv_reg    <= lv_reg + 4'd1;
                        key_reg   <= key_reg >> eff_chunk;
                        state_reg <= S_WALK_RD;
                    end
                end
                S_DEC_RD: begin
                    state_reg <= S_DEC_WR;
                end
                S_DEC_WR: begin
                    if (dec_cnt != '0) begin
                        state_reg <= S_FIN;
                    end else begin
                        if (head_reg < HB'(POOL_NODES)) begin
                            head_reg <= head_reg + 1'b1;
                        end
                        if (lv_reg == 4'd0) begin
                            root_pres_reg <= 1'b0;
                            root_reg      <= '0;
                            state_reg     <= S_FIN;
                        end else begin
                            node_reg  <= path_node_reg[up_lv];
                            lv_reg    <= lv_reg - 4'd1;
                            state_reg <= S_DEC_RD;
                        end
                    end
                end
                S_FIN: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        m_found_reg  <= found_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, 32'(m_found_reg), m_status_reg};

    logic idle_empty;
    logic pool_full;
    logic head_ok;

    assign idle_empty = (state_reg == S_IDLE) && !clr.busy && !root_pres_reg;
    assign pool_full  = head_reg == HB'(POOL_NODES);
    assign head_ok    = head_reg <= HB'(POOL_NODES);

    `FRHM_ASSERT_IMPL(a_no_accept_in_clear, aclk, aresetn, s_tready, !clr.busy, "ready in clear")
    `FRHM_ASSERT_ALWAYS(a_head_in_range, aclk, aresetn, head_ok, "free list head beyond pool")
    `FRHM_ASSERT_IMPL(a_empty_map_full_pool, aclk, aresetn, idle_empty, pool_full, "empty map not full")

endmodule
